/* design/soca_pkg.sv */
// Shared types and constants for the stereo overlap crossfade assembler.
`timescale 1ns / 1ps
`default_nettype none

package soca_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned MaxOverlapDef = 1024;
  localparam int unsigned WindowW       = 20;
  localparam int unsigned OverlapW      = 11;
  localparam int unsigned StepW         = 17;
  localparam int unsigned TargetW       = 32;
  localparam int unsigned PosW          = 20;
  localparam int unsigned RampW         = 17;
  localparam int unsigned Q16Frac       = 16;
  localparam int unsigned ProdW         = SampleW + 1 + RampW + 1;
  localparam int unsigned SumW          = SampleW + Q16Frac + 4;
  localparam int unsigned ApbAddrW      = 4;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoPtrW      = 2;
  localparam int unsigned FifoCntW      = 3;

  localparam logic [RampW-1:0] Q16One = 17'h10000;
  localparam logic [SumW-1:0]  Q16Half = 36'h8000;

  localparam logic [WindowW-1:0]  WindowRst  = 20'd4096;
  localparam logic [OverlapW-1:0] OverlapRst = 11'd1024;
  localparam logic [StepW-1:0]    StepRst    = 17'd64;
  localparam logic [TargetW-1:0]  TargetRst  = 32'd0;

  typedef enum logic [1:0] {
    RegWindow  = 2'd0,
    RegOverlap = 2'd1,
    RegStep    = 2'd2,
    RegTarget  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
    logic                      final_window;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic                      end_of_stream;
  } out_item_t;

  typedef struct packed {
    logic [WindowW-1:0]  window_samples;
    logic [OverlapW-1:0] overlap_len;
    logic [StepW-1:0]    alpha_step;
    logic [TargetW-1:0]  keep_count;
  } cfg_t;

  typedef struct packed {
    logic                      blend;
    logic                      wr;
    logic                      emit;
    logic                      eos;
    logic [RampW-1:0]          alpha;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } op_t;

endpackage

`default_nettype wire

/* design/soca_regs.sv */
// APB configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module soca_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [soca_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [soca_pkg::ApbDataW-1:0] pwdata,
  output logic      [soca_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output soca_pkg::cfg_t                     cfg_o
);
  import soca_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegWindow:  cfg_d.window_samples = pwdata[WindowW-1:0];
        RegOverlap: cfg_d.overlap_len    = pwdata[OverlapW-1:0];
        RegStep:    cfg_d.alpha_step     = pwdata[StepW-1:0];
        RegTarget:  cfg_d.keep_count     = pwdata[TargetW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegWindow:  prdata = ApbDataW'(cfg_q.window_samples);
      RegOverlap: prdata = ApbDataW'(cfg_q.overlap_len);
      RegStep:    prdata = ApbDataW'(cfg_q.alpha_step);
      RegTarget:  prdata = ApbDataW'(cfg_q.keep_count);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_samples <= WindowRst;
      cfg_q.overlap_len    <= OverlapRst;
      cfg_q.alpha_step     <= StepRst;
      cfg_q.keep_count     <= TargetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/soca_ctrl.sv */
// Window position, ramp and output count tracking; issues tail RAM addresses.
`timescale 1ns / 1ps
`default_nettype none

module soca_ctrl #(
  parameter int unsigned MAX_OVERLAP = soca_pkg::MaxOverlapDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  soca_pkg::in_item_t                  item_i,
  input  soca_pkg::cfg_t                      cfg_i,
  output soca_pkg::op_t                       op_o,
  output logic [$clog2(MAX_OVERLAP)-1:0]      rd_idx_o,
  output logic [$clog2(MAX_OVERLAP)-1:0]      wr_idx_o
);
  import soca_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_OVERLAP);
  localparam bit          IsPow2 = ((MAX_OVERLAP & (MAX_OVERLAP - 1)) == 0);
  localparam int unsigned ExtW  = PosW + 1;

  logic [PosW-1:0]    pos_q, pos_d;
  logic               first_q, first_d;
  logic [RampW-1:0]   ramp_q, ramp_d;
  logic [TargetW-1:0] emitted_q, emitted_d;

  logic [ExtW-1:0]    pos_x, win_x, ov_raw, ov_x, start_x, off_x;
  logic [PosW-1:0]    wr_off;
  logic [PosW:0]      wr_wrap;
  logic [RampW-1:0]   alpha, ramp_sat;
  logic [RampW:0]     ramp_sum;
  logic [TargetW:0]   emitted_inc;
  logic               blend, in_tail, last, emit;

  always_comb begin
    pos_x  = {1'b0, pos_q};
    win_x  = ExtW'(cfg_i.window_samples);
    ov_raw = ExtW'(cfg_i.overlap_len);
    ov_x   = (ov_raw > ExtW'(MAX_OVERLAP)) ? ExtW'(MAX_OVERLAP) : ov_raw;

    alpha    = (pos_q == '0) ? '0 : ramp_q;
    blend    = !first_q && (pos_x < ov_x);
    ramp_sum = {1'b0, alpha} + {1'b0, cfg_i.alpha_step};
    ramp_sat = (ramp_sum > {1'b0, Q16One}) ? Q16One : ramp_sum[RampW-1:0];

    in_tail = !item_i.final_window && ((pos_x + ov_x) >= win_x);
    start_x = (win_x > ov_x) ? (win_x - ov_x) : '0;
    off_x   = pos_x - start_x;
    wr_off  = off_x[PosW-1:0];
    wr_wrap = {1'b0, wr_off} - (PosW + 1)'(MAX_OVERLAP);
    if (IsPow2) begin
      wr_idx_o = wr_off[IdxW-1:0];
    end else if (wr_off >= PosW'(MAX_OVERLAP)) begin
      wr_idx_o = wr_wrap[IdxW-1:0];
    end else begin
      wr_idx_o = wr_off[IdxW-1:0];
    end
    rd_idx_o = pos_q[IdxW-1:0];

    emitted_inc = {1'b0, emitted_q} + (TargetW + 1)'(1);
    emit = !in_tail && (emitted_q < cfg_i.keep_count);
    last = (pos_x + ExtW'(1)) >= win_x;

    op_o.blend = blend;
    op_o.wr    = in_tail;
    op_o.emit  = emit;
    op_o.eos   = (emitted_inc == {1'b0, cfg_i.keep_count});
    op_o.alpha = alpha;
    op_o.left  = item_i.left_in;
    op_o.right = item_i.right_in;

    pos_d     = pos_q;
    first_d   = first_q;
    ramp_d    = ramp_q;
    emitted_d = emitted_q;
    if (accept_i) begin
      ramp_d    = blend ? ramp_sat : alpha;
      emitted_d = emit ? emitted_inc[TargetW-1:0] : emitted_q;
      if (last) begin
        pos_d   = '0;
        first_d = item_i.final_window;
        if (item_i.final_window) begin
          emitted_d = '0;
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      first_q   <= 1'b1;
      ramp_q    <= '0;
      emitted_q <= '0;
    end else begin
      pos_q     <= pos_d;
      first_q   <= first_d;
      ramp_q    <= ramp_d;
      emitted_q <= emitted_d;
    end
  end

  a_ramp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_q <= Q16One)
    else $error("ramp above unity");

  a_stream_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last && item_i.final_window |=>
      (pos_q == '0) && first_q && (emitted_q == '0))
    else $error("stream state not restarted after final window");

endmodule

`default_nettype wire

/* design/soca_tail_ram.sv */
// Tail sample store: one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module soca_tail_ram #(
  parameter int unsigned MAX_OVERLAP = soca_pkg::MaxOverlapDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [$clog2(MAX_OVERLAP)-1:0]  wr_idx_i,
  input  wire logic [2*soca_pkg::SampleW-1:0]  wr_data_i,
  input  wire logic [$clog2(MAX_OVERLAP)-1:0]  rd_idx_i,
  output logic      [2*soca_pkg::SampleW-1:0]  rd_data_o
);
  import soca_pkg::*;

  logic [2*SampleW-1:0] mem [MAX_OVERLAP];
  logic [2*SampleW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_q <= mem[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* design/soca_blend.sv */
// Two-stage crossfade datapath with tail forwarding and write-back.
`timescale 1ns / 1ps
`default_nettype none

module soca_blend #(
  parameter int unsigned MAX_OVERLAP = soca_pkg::MaxOverlapDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  soca_pkg::op_t                        op_i,
  input  wire logic [$clog2(MAX_OVERLAP)-1:0]  rd_idx_i,
  input  wire logic [$clog2(MAX_OVERLAP)-1:0]  wr_idx_i,
  input  wire logic [2*soca_pkg::SampleW-1:0]  rd_data_i,
  output logic                                 we_o,
  output logic [$clog2(MAX_OVERLAP)-1:0]       wr_idx_o,
  output logic [2*soca_pkg::SampleW-1:0]       wr_data_o,
  output logic                                 push_o,
  output soca_pkg::out_item_t                  push_data_o,
  output logic [1:0]                           inflight_o
);
  import soca_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_OVERLAP);

  // stage 1: tail data arrives
  logic             s1_v_q;
  op_t              s1_op_q;
  logic [IdxW-1:0]  s1_rd_idx_q, s1_wr_idx_q;

  // stage 2: product ready
  logic                      s2_v_q, s2_wr_q, s2_emit_q, s2_eos_q;
  logic [IdxW-1:0]           s2_wr_idx_q;
  logic signed [SampleW-1:0] s2_old_l_q, s2_old_r_q;
  logic signed [ProdW-1:0]   s2_prod_l_q, s2_prod_r_q;

  // last write-back, for reads issued at the same edge
  logic                      lw_v_q;
  logic [IdxW-1:0]           lw_idx_q;
  logic [2*SampleW-1:0]      lw_data_q;

  logic [2*SampleW-1:0]      tail, s2_res;
  logic signed [SampleW-1:0] old_l, old_r, res_l, res_r;
  logic signed [SampleW:0]   diff_l, diff_r;
  logic signed [RampW:0]     alpha_s;
  logic signed [ProdW-1:0]   prod_l, prod_r;
  logic signed [SumW-1:0]    acc_l, acc_r;

  always_comb begin
    if (s2_v_q && s2_wr_q && (s2_wr_idx_q == s1_rd_idx_q)) begin
      tail = s2_res;
    end else if (lw_v_q && (lw_idx_q == s1_rd_idx_q)) begin
      tail = lw_data_q;
    end else begin
      tail = rd_data_i;
    end
    old_l   = s1_op_q.blend ? $signed(tail[2*SampleW-1:SampleW]) : s1_op_q.left;
    old_r   = s1_op_q.blend ? $signed(tail[SampleW-1:0])         : s1_op_q.right;
    diff_l  = {s1_op_q.left[SampleW-1], s1_op_q.left} - {old_l[SampleW-1], old_l};
    diff_r  = {s1_op_q.right[SampleW-1], s1_op_q.right} - {old_r[SampleW-1], old_r};
    alpha_s = $signed({1'b0, s1_op_q.alpha});
    prod_l  = diff_l * alpha_s;
    prod_r  = diff_r * alpha_s;
  end

  always_comb begin
    acc_l  = $signed({{4{s2_old_l_q[SampleW-1]}}, s2_old_l_q, {Q16Frac{1'b0}}})
           + $signed({s2_prod_l_q[ProdW-1], s2_prod_l_q}) + $signed(Q16Half);
    acc_r  = $signed({{4{s2_old_r_q[SampleW-1]}}, s2_old_r_q, {Q16Frac{1'b0}}})
           + $signed({s2_prod_r_q[ProdW-1], s2_prod_r_q}) + $signed(Q16Half);
    res_l  = acc_l[Q16Frac +: SampleW];
    res_r  = acc_r[Q16Frac +: SampleW];
    s2_res = {res_l, res_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
      lw_v_q <= s2_v_q && s2_wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q     <= op_i;
    s1_rd_idx_q <= rd_idx_i;
    s1_wr_idx_q <= wr_idx_i;
    s2_wr_q     <= s1_op_q.wr;
    s2_emit_q   <= s1_op_q.emit;
    s2_eos_q    <= s1_op_q.eos;
    s2_wr_idx_q <= s1_wr_idx_q;
    s2_old_l_q  <= old_l;
    s2_old_r_q  <= old_r;
    s2_prod_l_q <= prod_l;
    s2_prod_r_q <= prod_r;
    lw_idx_q    <= s2_wr_idx_q;
    lw_data_q   <= s2_res;
  end

  assign we_o       = s2_v_q && s2_wr_q;
  assign wr_idx_o   = s2_wr_idx_q;
  assign wr_data_o  = s2_res;
  assign push_o     = s2_v_q && s2_emit_q;
  assign push_data_o.left_out      = res_l;
  assign push_data_o.right_out     = res_r;
  assign push_data_o.end_of_stream = s2_eos_q;
  assign inflight_o = {1'b0, s1_v_q} + {1'b0, s2_v_q};

endmodule

`default_nettype wire

/* design/soca_out_fifo.sv */
// Result queue with room check that counts items still in the datapath.
`timescale 1ns / 1ps
`default_nettype none

module soca_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  soca_pkg::out_item_t data_i,
  input  wire logic [1:0]     inflight_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output soca_pkg::out_item_t out_data_o
);
  import soca_pkg::*;

  out_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign full_o      = ({1'b0, cnt_q} + {2'b0, inflight_i}) >= (FifoCntW + 1)'(FifoDepth);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + FifoCntW'(1);
      2'b01:   cnt_d = cnt_q - FifoCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != FifoCntW'(FifoDepth)) || pop)
    else $error("result queue overflow");

endmodule

`default_nettype wire

/* design/stereo_overlap_crossfade_assembler_top.sv */
// Top level of the stereo overlap crossfade assembler.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   config   input      APB psel/penable/pready   pwdata/prdata, paddr = 4*index
//
// One transfer per cycle unless in_stall_o; each result passes both stages and the queue.
// Rate is set by the tail RAM: one read (issue) and one write (write-back) per cycle.
// Tail store is not cleared at reset; it holds nothing until tail samples are written.
// A four-entry result queue absorbs output stalls; input stalls once the queue
// plus the two datapath stages could fill it.
`timescale 1ns / 1ps
`default_nettype none

module stereo_overlap_crossfade_assembler_top #(
  parameter int unsigned MAX_OVERLAP = soca_pkg::MaxOverlapDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  soca_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output soca_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [soca_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [soca_pkg::ApbDataW-1:0] pwdata,
  output logic      [soca_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import soca_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_OVERLAP);

  cfg_t                 cfg;
  op_t                  op;
  out_item_t            push_data;
  logic                 accept, full, we, push;
  logic [IdxW-1:0]      rd_idx, wr_idx, mem_wr_idx;
  logic [2*SampleW-1:0] rd_data, wr_data;
  logic [1:0]           inflight;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  soca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  soca_ctrl #(.MAX_OVERLAP(MAX_OVERLAP)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .op_o     (op),
    .rd_idx_o (rd_idx),
    .wr_idx_o (wr_idx)
  );

  soca_tail_ram #(.MAX_OVERLAP(MAX_OVERLAP)) u_tail_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_idx_i  (mem_wr_idx),
    .wr_data_i (wr_data),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  soca_blend #(.MAX_OVERLAP(MAX_OVERLAP)) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op),
    .rd_idx_i    (rd_idx),
    .wr_idx_i    (wr_idx),
    .rd_data_i   (rd_data),
    .we_o        (we),
    .wr_idx_o    (mem_wr_idx),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_data_o (push_data),
    .inflight_o  (inflight)
  );

  soca_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (push_data),
    .inflight_i  (inflight),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
